### rtl/xed_pkg.sv
package xed_pkg;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_XLO  = 8'h78;
  localparam logic [7:0] CH_XUP  = 8'h58;

  localparam logic [20:0] CP_SAT  = 21'h110000;
  localparam logic [20:0] CP_MAX1 = 21'h00007F;
  localparam logic [20:0] CP_MAX2 = 21'h0007FF;
  localparam logic [20:0] CP_MAX3 = 21'h00FFFF;
  localparam logic [20:0] CP_MAX4 = 21'h10FFFF;

  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_CONT  = 8'h80;

  localparam int F_NUM   = 0;
  localparam int F_HEX   = 1;
  localparam int F_DIGIT = 2;
  localparam int F_STOP  = 3;

  localparam logic [2:0] SRC_IN   = 3'd0;
  localparam logic [2:0] SRC_AMP  = 3'd1;
  localparam logic [2:0] SRC_RES  = 3'd2;
  localparam logic [2:0] SRC_BUF  = 3'd3;
  localparam logic [2:0] SRC_TAIL = 3'd4;
  localparam logic [2:0] SRC_UTF  = 3'd5;

  typedef struct packed {
    logic       push;
    logic       clear;
    logic       fl_start;
    logic       tail_in;
    logic       idx_step;
    logic       out_load;
    logic [2:0] out_sel;
    logic       out_last;
    logic       utf_load;
    logic       utf_shift;
  } cmd_t;

  typedef struct packed {
    logic       can_load;
    logic       in_amp;
    logic       in_semi;
    logic       name_full;
    logic       fl_empty;
    logic       fl_at_end;
    logic       res_flush;
    logic [2:0] res_count;
  } sts_t;

endpackage

### rtl/xed_ctrl.sv
module xed_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tlast,
  output logic          s_axis_tready,
  input  xed_pkg::sts_t sts,
  output xed_pkg::cmd_t cmd
);

  localparam logic [2:0] S_RUN  = 3'd0;
  localparam logic [2:0] S_AMP  = 3'd1;
  localparam logic [2:0] S_BUF  = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_UTF  = 3'd4;

  localparam logic [1:0] M_NORMAL = 2'd0;
  localparam logic [1:0] M_NAME   = 2'd1;
  localparam logic [1:0] M_SKIP   = 2'd2;

  logic [2:0] state, state_next;
  logic [1:0] mode, mode_next;
  logic       tail_en, tail_en_next;
  logic [1:0] rem, rem_next;
  logic       accept;

  assign s_axis_tready = (state == S_RUN) && sts.can_load;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd = '0;
    state_next = state;
    mode_next = mode;
    tail_en_next = tail_en;
    rem_next = rem;
    case (state)
      S_RUN: begin
        if (accept) begin
          case (mode)
            M_NAME: begin
              if (sts.in_semi) begin
                cmd.clear = 1'b1;
                mode_next = M_NORMAL;
                if (sts.res_flush) begin
                  cmd.fl_start = 1'b1;
                  cmd.tail_in = 1'b0;
                  tail_en_next = 1'b1;
                  state_next = S_AMP;
                end else if (sts.res_count != 3'd0) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel = xed_pkg::SRC_RES;
                  cmd.out_last = (sts.res_count == 3'd1);
                  cmd.utf_load = 1'b1;
                  rem_next = 2'(sts.res_count - 3'd1);
                  if (sts.res_count != 3'd1) begin
                    state_next = S_UTF;
                  end
                end
              end else if (!sts.name_full) begin
                cmd.push = 1'b1;
                if (s_axis_tlast) begin
                  cmd.fl_start = 1'b1;
                  tail_en_next = 1'b0;
                  state_next = S_AMP;
                end
              end else begin
                cmd.clear = 1'b1;
                cmd.fl_start = 1'b1;
                cmd.tail_in = 1'b1;
                tail_en_next = 1'b1;
                mode_next = M_SKIP;
                state_next = S_AMP;
              end
            end
            M_SKIP: begin
              cmd.out_load = 1'b1;
              cmd.out_sel = xed_pkg::SRC_IN;
              cmd.out_last = 1'b1;
              if (sts.in_semi) begin
                mode_next = M_NORMAL;
              end
            end
            default: begin
              if (sts.in_amp) begin
                cmd.clear = 1'b1;
                mode_next = M_NAME;
                if (s_axis_tlast) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel = xed_pkg::SRC_AMP;
                  cmd.out_last = 1'b1;
                end
              end else begin
                cmd.out_load = 1'b1;
                cmd.out_sel = xed_pkg::SRC_IN;
                cmd.out_last = 1'b1;
              end
            end
          endcase
          if (s_axis_tlast) begin
            mode_next = M_NORMAL;
            cmd.clear = 1'b1;
          end
        end
      end
      S_AMP: begin
        if (sts.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel = xed_pkg::SRC_AMP;
          cmd.out_last = sts.fl_empty && !tail_en;
          if (!sts.fl_empty) begin
            state_next = S_BUF;
          end else if (tail_en) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_BUF: begin
        if (sts.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel = xed_pkg::SRC_BUF;
          cmd.out_last = sts.fl_at_end && !tail_en;
          cmd.idx_step = 1'b1;
          if (sts.fl_at_end) begin
            state_next = tail_en ? S_TAIL : S_RUN;
          end
        end
      end
      S_TAIL: begin
        if (sts.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel = xed_pkg::SRC_TAIL;
          cmd.out_last = 1'b1;
          state_next = S_RUN;
        end
      end
      S_UTF: begin
        if (sts.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sel = xed_pkg::SRC_UTF;
          cmd.out_last = (rem == 2'd1);
          cmd.utf_shift = 1'b1;
          rem_next = rem - 2'd1;
          if (rem == 2'd1) begin
            state_next = S_RUN;
          end
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      mode <= M_NORMAL;
      tail_en <= 1'b0;
      rem <= 2'd0;
    end else begin
      state <= state_next;
      mode <= mode_next;
      tail_en <= tail_en_next;
      rem <= rem_next;
    end
  end

endmodule

### rtl/xed_dp.sv
module xed_dp #(
  parameter int MAX_NAME_BYTES = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_byte,
  input  xed_pkg::cmd_t cmd,
  output xed_pkg::sts_t sts,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  localparam int LW = $clog2(MAX_NAME_BYTES + 1);
  localparam int IW = $clog2(MAX_NAME_BYTES);

  logic [LW-1:0] len;
  logic [20:0]   value;
  logic [3:0]    flags;
  logic [7:0]    hd [4];
  logic [7:0]    mem [MAX_NAME_BYTES];
  logic [7:0]    rd_data;
  logic [LW-1:0] fl_len;
  logic [IW-1:0] idx, idx_next;
  logic [7:0]    tail;
  logic [7:0]    utf_q [3];

  logic          dv;
  logic [3:0]    dval;
  logic [25:0]   acc, sum;
  logic [20:0]   value_push, value_nx;
  logic [3:0]    flags_nx;
  logic          hit;
  logic [7:0]    ent;
  logic [7:0]    enc [4];
  logic [2:0]    enc_cnt;
  logic [7:0]    res [4];
  logic          res_flush;
  logic [2:0]    res_count;
  logic          at_end;
  logic [7:0]    out_mux;

  always_comb begin
    dv = 1'b0;
    dval = 4'd0;
    if (in_byte >= "0" && in_byte <= "9") begin
      dv = 1'b1;
      dval = in_byte[3:0];
    end else if (flags[xed_pkg::F_HEX] && ((in_byte >= "a" && in_byte <= "f") ||
                                           (in_byte >= "A" && in_byte <= "F"))) begin
      dv = 1'b1;
      dval = in_byte[3:0] + 4'd9;
    end
  end

  always_comb begin
    if (flags[xed_pkg::F_HEX]) begin
      acc = 26'({value, 4'b0000});
    end else begin
      acc = 26'({value, 3'b000}) + 26'({value, 1'b0});
    end
    sum = acc + 26'(dval);
    value_push = (sum > 26'(xed_pkg::CP_SAT)) ? xed_pkg::CP_SAT : sum[20:0];
  end

  always_comb begin
    flags_nx = flags;
    value_nx = value;
    if (len == '0) begin
      if (in_byte == xed_pkg::CH_HASH) begin
        flags_nx[xed_pkg::F_NUM] = 1'b1;
      end
    end else if (flags[xed_pkg::F_NUM] && !flags[xed_pkg::F_STOP]) begin
      if (len == LW'(1) && (in_byte == xed_pkg::CH_XLO || in_byte == xed_pkg::CH_XUP)) begin
        flags_nx[xed_pkg::F_HEX] = 1'b1;
      end else if (!dv) begin
        flags_nx[xed_pkg::F_STOP] = 1'b1;
      end else begin
        flags_nx[xed_pkg::F_DIGIT] = 1'b1;
        value_nx = value_push;
      end
    end
  end

  always_comb begin
    hit = 1'b1;
    ent = xed_pkg::CH_LT;
    if (len == LW'(2) && {hd[0], hd[1]} == "lt") begin
      ent = xed_pkg::CH_LT;
    end else if (len == LW'(2) && {hd[0], hd[1]} == "gt") begin
      ent = xed_pkg::CH_GT;
    end else if (len == LW'(3) && {hd[0], hd[1], hd[2]} == "amp") begin
      ent = xed_pkg::CH_AMP;
    end else if (len == LW'(4) && {hd[0], hd[1], hd[2], hd[3]} == "quot") begin
      ent = xed_pkg::CH_QUOT;
    end else if (len == LW'(4) && {hd[0], hd[1], hd[2], hd[3]} == "apos") begin
      ent = xed_pkg::CH_APOS;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      enc[i] = 8'h00;
    end
    enc_cnt = 3'd0;
    if (value <= xed_pkg::CP_MAX1) begin
      enc_cnt = 3'd1;
      enc[0] = value[7:0];
    end else if (value <= xed_pkg::CP_MAX2) begin
      enc_cnt = 3'd2;
      enc[0] = xed_pkg::UTF_LEAD2 | {3'b000, value[10:6]};
      enc[1] = xed_pkg::UTF_CONT | {2'b00, value[5:0]};
    end else if (value <= xed_pkg::CP_MAX3) begin
      enc_cnt = 3'd3;
      enc[0] = xed_pkg::UTF_LEAD3 | {4'b0000, value[15:12]};
      enc[1] = xed_pkg::UTF_CONT | {2'b00, value[11:6]};
      enc[2] = xed_pkg::UTF_CONT | {2'b00, value[5:0]};
    end else if (value <= xed_pkg::CP_MAX4) begin
      enc_cnt = 3'd4;
      enc[0] = xed_pkg::UTF_LEAD4 | {5'b00000, value[20:18]};
      enc[1] = xed_pkg::UTF_CONT | {2'b00, value[17:12]};
      enc[2] = xed_pkg::UTF_CONT | {2'b00, value[11:6]};
      enc[3] = xed_pkg::UTF_CONT | {2'b00, value[5:0]};
    end
  end

  always_comb begin
    res = enc;
    res_flush = 1'b0;
    res_count = enc_cnt;
    if (hit) begin
      res[0] = ent;
      res_count = 3'd1;
    end else if (!(flags[xed_pkg::F_NUM] && flags[xed_pkg::F_DIGIT])) begin
      res_flush = 1'b1;
      res_count = 3'd0;
    end
  end

  assign at_end = (LW'(idx) + LW'(1)) == fl_len;

  always_comb begin
    if (cmd.fl_start) begin
      idx_next = '0;
    end else if (cmd.idx_step) begin
      idx_next = at_end ? '0 : idx + IW'(1);
    end else begin
      idx_next = idx;
    end
  end

  always_comb begin
    case (cmd.out_sel)
      xed_pkg::SRC_IN:   out_mux = in_byte;
      xed_pkg::SRC_AMP:  out_mux = xed_pkg::CH_AMP;
      xed_pkg::SRC_RES:  out_mux = res[0];
      xed_pkg::SRC_BUF:  out_mux = rd_data;
      xed_pkg::SRC_TAIL: out_mux = tail;
      xed_pkg::SRC_UTF:  out_mux = utf_q[0];
      default:           out_mux = in_byte;
    endcase
  end

  assign sts = '{
    can_load:  !out_valid || out_ready,
    in_amp:    (in_byte == xed_pkg::CH_AMP),
    in_semi:   (in_byte == xed_pkg::CH_SEMI),
    name_full: (len == LW'(MAX_NAME_BYTES)),
    fl_empty:  (fl_len == '0),
    fl_at_end: at_end,
    res_flush: res_flush,
    res_count: res_count
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      len <= '0;
      value <= '0;
      flags <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        len <= '0;
        value <= '0;
        flags <= '0;
      end else if (cmd.push) begin
        len <= len + LW'(1);
        value <= value_nx;
        flags <= flags_nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte <= out_mux;
      out_last <= cmd.out_last;
    end
    if (cmd.push) begin
      mem[len[IW-1:0]] <= in_byte;
      if (len < LW'(4)) begin
        hd[len[1:0]] <= in_byte;
      end
    end
    rd_data <= mem[idx_next];
    idx <= idx_next;
    if (cmd.fl_start) begin
      fl_len <= cmd.push ? len + LW'(1) : len;
      tail <= cmd.tail_in ? in_byte : xed_pkg::CH_SEMI;
    end
    if (cmd.utf_load) begin
      utf_q[0] <= res[1];
      utf_q[1] <= res[2];
      utf_q[2] <= res[3];
    end else if (cmd.utf_shift) begin
      utf_q[0] <= utf_q[1];
      utf_q[1] <= utf_q[2];
    end
  end

endmodule

### rtl/xml_entity_decoder_unit.sv
// Channel  Dir  tdata (low bit up)  tlast        Handshake
// s_axis   in   data_byte[7:0]      last         tvalid & tready
// m_axis   out  out_byte[7:0]       end_of_run   tvalid & tready
//
// A plain byte, a named entity or a buffered name byte is sent as one output byte.
// A numeric reference is sent as one to four UTF-8 bytes, and the input is held
// until the last is loaded; when its value is out of range, nothing is sent.
// A verbatim copy of a reference sends the ampersand, then the buffered name bytes,
// one name memory read per cycle unless the output stalls, then any tail byte.
// Reset returns the block to plain text mode with an empty name and no pending item.
// A stalled output register holds the input side as well.
module xml_entity_decoder_unit #(
  parameter int MAX_NAME_BYTES = 30
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  xed_pkg::cmd_t cmd;
  xed_pkg::sts_t sts;

  xed_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  xed_dp #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

### tb/sv/xml_entity_decoder_unit_test.sv
module xml_entity_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_BYTES = 30;
  localparam int DIR_ROWS = 23;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {SCAN_TEXT, SCAN_NAME, SCAN_SKIP} scan_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eor;
  } out_item_t;

  typedef struct packed {
    logic [7:0]      data;
    logic            last;
    logic            typed;
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
  } dir_row_t;

  // Rows with typed set carry their expected bytes, the first one in the lowest byte.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h41,            1'b0, 1'b1, 3'd1, 32'h41},
    '{8'hFF,            1'b0, 1'b1, 3'd1, 32'hFF},
    '{8'h00,            1'b0, 1'b1, 3'd1, 32'h00},
    '{xed_pkg::CH_AMP,  1'b0, 1'b1, 3'd0, 32'h00},
    '{"g",              1'b0, 1'b0, 3'd0, 32'h00},
    '{"t",              1'b0, 1'b0, 3'd0, 32'h00},
    '{xed_pkg::CH_SEMI, 1'b0, 1'b1, 3'd1, {24'h0, xed_pkg::CH_GT}},
    '{xed_pkg::CH_AMP,  1'b0, 1'b0, 3'd0, 32'h00},
    '{xed_pkg::CH_HASH, 1'b0, 1'b0, 3'd0, 32'h00},
    '{xed_pkg::CH_SEMI, 1'b0, 1'b1, 3'd3,
      {8'h00, xed_pkg::CH_SEMI, xed_pkg::CH_HASH, xed_pkg::CH_AMP}},
    '{xed_pkg::CH_AMP,  1'b0, 1'b0, 3'd0, 32'h00},
    '{xed_pkg::CH_HASH, 1'b0, 1'b0, 3'd0, 32'h00},
    '{"0",              1'b0, 1'b0, 3'd0, 32'h00},
    '{xed_pkg::CH_SEMI, 1'b0, 1'b1, 3'd1, 32'h00},
    '{xed_pkg::CH_AMP,  1'b0, 1'b0, 3'd0, 32'h00},
    '{"q",              1'b1, 1'b1, 3'd2, {16'h0, 8'h71, xed_pkg::CH_AMP}},
    '{xed_pkg::CH_AMP,  1'b1, 1'b1, 3'd1, {24'h0, xed_pkg::CH_AMP}},
    '{xed_pkg::CH_AMP,  1'b0, 1'b0, 3'd0, 32'h00},
    '{xed_pkg::CH_HASH, 1'b0, 1'b0, 3'd0, 32'h00},
    '{"1",              1'b0, 1'b0, 3'd0, 32'h00},
    '{"z",              1'b0, 1'b0, 3'd0, 32'h00},
    '{"2",              1'b0, 1'b0, 3'd0, 32'h00},
    '{xed_pkg::CH_SEMI, 1'b0, 1'b1, 3'd1, 32'h01}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  logic        hold_off = 1'b0;
  int          phase = 0;
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  scan_mode_t  scan_mode = SCAN_TEXT;
  logic [7:0]  name_buf [NAME_BYTES];
  int          name_len = 0;
  logic [20:0] num_value = '0;
  logic [3:0]  num_flags = '0;

  logic [7:0]  decoded [$];
  out_item_t   expected_q [$];
  in_item_t    text_q [$];

  xml_entity_decoder_unit #(
    .MAX_NAME_BYTES(NAME_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void clear_name();
    name_len = 0;
    num_value = '0;
    num_flags = '0;
  endfunction

  function automatic void flush_name();
    int i;
    decoded.push_back(xed_pkg::CH_AMP);
    for (i = 0; i < name_len; i++) decoded.push_back(name_buf[i]);
  endfunction

  function automatic bit name_matches(input string s);
    int i;
    if (name_len != s.len()) return 1'b0;
    for (i = 0; i < name_len; i++) begin
      if (name_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the bytes that one accepted input item causes and updates the decoder state.
  function automatic void decode_item(input logic [7:0] c, input logic fin);
    int          digit;
    logic [31:0] acc;
    decoded.delete();
    case (scan_mode)
      SCAN_NAME: begin
        if (c == xed_pkg::CH_SEMI) begin
          if (name_matches("lt")) decoded.push_back(xed_pkg::CH_LT);
          else if (name_matches("gt")) decoded.push_back(xed_pkg::CH_GT);
          else if (name_matches("amp")) decoded.push_back(xed_pkg::CH_AMP);
          else if (name_matches("quot")) decoded.push_back(xed_pkg::CH_QUOT);
          else if (name_matches("apos")) decoded.push_back(xed_pkg::CH_APOS);
          else if (!num_flags[xed_pkg::F_NUM] || !num_flags[xed_pkg::F_DIGIT]) begin
            flush_name();
            decoded.push_back(xed_pkg::CH_SEMI);
          end else if (num_value <= xed_pkg::CP_MAX1) begin
            decoded.push_back(num_value[7:0]);
          end else if (num_value <= xed_pkg::CP_MAX2) begin
            decoded.push_back(xed_pkg::UTF_LEAD2 | 8'(num_value >> 6));
            decoded.push_back(xed_pkg::UTF_CONT | {2'b00, num_value[5:0]});
          end else if (num_value <= xed_pkg::CP_MAX3) begin
            decoded.push_back(xed_pkg::UTF_LEAD3 | 8'(num_value >> 12));
            decoded.push_back(xed_pkg::UTF_CONT | {2'b00, num_value[11:6]});
            decoded.push_back(xed_pkg::UTF_CONT | {2'b00, num_value[5:0]});
          end else if (num_value <= xed_pkg::CP_MAX4) begin
            decoded.push_back(xed_pkg::UTF_LEAD4 | 8'(num_value >> 18));
            decoded.push_back(xed_pkg::UTF_CONT | {2'b00, num_value[17:12]});
            decoded.push_back(xed_pkg::UTF_CONT | {2'b00, num_value[11:6]});
            decoded.push_back(xed_pkg::UTF_CONT | {2'b00, num_value[5:0]});
          end
          scan_mode = SCAN_TEXT;
          clear_name();
        end else if (name_len < NAME_BYTES) begin
          if (name_len == 0) begin
            if (c == xed_pkg::CH_HASH) num_flags[xed_pkg::F_NUM] = 1'b1;
          end else if (num_flags[xed_pkg::F_NUM] && !num_flags[xed_pkg::F_STOP]) begin
            if (name_len == 1 && (c == xed_pkg::CH_XLO || c == xed_pkg::CH_XUP)) begin
              num_flags[xed_pkg::F_HEX] = 1'b1;
            end else begin
              digit = -1;
              if (c >= "0" && c <= "9") digit = c - "0";
              else if (num_flags[xed_pkg::F_HEX] && c >= "a" && c <= "f") digit = c - "a" + 10;
              else if (num_flags[xed_pkg::F_HEX] && c >= "A" && c <= "F") digit = c - "A" + 10;
              if (digit < 0) begin
                num_flags[xed_pkg::F_STOP] = 1'b1;
              end else begin
                num_flags[xed_pkg::F_DIGIT] = 1'b1;
                acc = num_value * (num_flags[xed_pkg::F_HEX] ? 32'd16 : 32'd10) + 32'(digit);
                num_value = (acc > 32'(xed_pkg::CP_SAT)) ? xed_pkg::CP_SAT : acc[20:0];
              end
            end
          end
          name_buf[name_len] = c;
          name_len++;
          if (fin) flush_name();
        end else begin
          flush_name();
          decoded.push_back(c);
          scan_mode = SCAN_SKIP;
          clear_name();
        end
      end
      SCAN_SKIP: begin
        decoded.push_back(c);
        if (c == xed_pkg::CH_SEMI) scan_mode = SCAN_TEXT;
      end
      default: begin
        if (c == xed_pkg::CH_AMP) begin
          scan_mode = SCAN_NAME;
          clear_name();
          if (fin) decoded.push_back(xed_pkg::CH_AMP);
        end else begin
          decoded.push_back(c);
        end
      end
    endcase
    if (fin) begin
      scan_mode = SCAN_TEXT;
      clear_name();
    end
  endfunction

  function automatic void queue_decoded();
    int i;
    for (i = 0; i < decoded.size(); i++) begin
      expected_q.push_back('{data: decoded[i], eor: (i == decoded.size() - 1)});
    end
  endfunction

  task automatic offer_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back('{data: s[i], last: 1'b0});
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == xed_pkg::CH_SEMI);
    return b;
  endfunction

  // Builds one run of text: plain bytes or a reference, well-formed or malformed, with random content.
  function automatic void build_chunk(input int kind);
    string       names [7] = '{"lt", "gt", "amp", "quot", "apos", "am", "quote"};
    string       empties [4] = '{"#", "#x", "#X", "#xq"};
    int unsigned cp_lo [7] = '{'h0, 'h80, 'h800, 'hD800, 'h10000, 'h110000, 'h1000000};
    int unsigned cp_hi [7] = '{'h7F, 'h7FF, 'hFFFF, 'hDFFF, 'h10FFFF, 'h1FFFFF, 'hFFFFFFF};
    int unsigned cp;
    int          cls;
    int          n;
    int          i;
    bit          hex;
    string       digits;
    text_q.delete();
    if (kind < 20) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) text_q.push_back('{data: 8'($urandom_range(0, 255)), last: 1'b0});
    end else if (kind < 35) begin
      push_text({"&", names[$urandom_range(0, 6)], ";"});
    end else if (kind < 70) begin
      hex = $urandom_range(0, 1);
      cls = $urandom_range(0, 6);
      cp = $urandom_range(cp_lo[cls], cp_hi[cls]);
      if ($urandom_range(0, 3) == 0) cp = $urandom_range(0, 1) ? cp_lo[cls] : cp_hi[cls];
      push_text("&#");
      if (hex) begin
        text_q.push_back('{data: ($urandom_range(0, 1) ? xed_pkg::CH_XUP : xed_pkg::CH_XLO),
                           last: 1'b0});
      end
      repeat ($urandom_range(0, 2)) push_text("0");
      digits = hex ? $sformatf("%0h", cp) : $sformatf("%0d", cp);
      for (i = 0; i < digits.len(); i++) begin
        if (digits[i] >= "a" && digits[i] <= "f" && $urandom_range(0, 1))
          digits[i] = digits[i] - 8'h20;
      end
      push_text(digits);
      if ($urandom_range(0, 4) == 0) push_text($sformatf("z%0d", $urandom_range(0, 999)));
      push_text(";");
    end else if (kind < 78) begin
      push_text({"&", empties[$urandom_range(0, 3)], ";"});
    end else if (kind < 88) begin
      push_text("&");
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) text_q.push_back('{data: name_byte(), last: 1'b0});
      push_text(";");
    end else if (kind < 96) begin
      push_text("&");
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) text_q.push_back('{data: name_byte(), last: 1'b0});
      text_q[text_q.size() - 1].last = 1'b1;
    end else begin
      push_text("&");
      n = $urandom_range(NAME_BYTES, NAME_BYTES + 4);
      for (i = 0; i < n; i++) text_q.push_back('{data: name_byte(), last: 1'b0});
      push_text(";");
    end
    if ($urandom_range(0, 9) == 0) text_q[$urandom_range(0, text_q.size() - 1)].last = 1'b1;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_gap_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("unexpected item data %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata !== want.data)
          log_mismatch($sformatf("data expected %h actual %h", want.data, m_axis_tdata));
        if (m_axis_tlast !== want.eor)
          log_mismatch($sformatf("last expected %b actual %b", want.eor, m_axis_tlast));
      end
    end
  end

  // The receiver holds off long enough for the block to fill up and stall its input.
  initial begin
    wait (phase == 3);
    repeat (20) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int send_pcts [3];
    int recv_pcts [3];
    int sent;
    int r;
    int j;
    send_pcts = '{38, 67, 0};
    recv_pcts = '{67, 38, 0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (phase = 1; phase <= 3; phase++) begin
      send_gap_pct = send_pcts[phase - 1];
      recv_gap_pct = recv_pcts[phase - 1];
      if (phase == 1) begin
        for (r = 0; r < DIR_ROWS; r++) begin
          offer_byte(DIRECTED[r].data, DIRECTED[r].last);
          decode_item(DIRECTED[r].data, DIRECTED[r].last);
          if (DIRECTED[r].typed) begin
            decoded.delete();
            for (j = 0; j < DIRECTED[r].count; j++) decoded.push_back(DIRECTED[r].bytes[j]);
          end
          queue_decoded();
        end
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        build_chunk((phase == 2 && sent == 0) ? 99 : $urandom_range(0, 99));
        sent += text_q.size();
        for (j = 0; j < text_q.size(); j++) begin
          offer_byte(text_q[j].data, text_q[j].last);
          decode_item(text_q[j].data, text_q[j].last);
          queue_decoded();
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
